[src/rrrob_pkg.sv]
// Shared types, constants and helper functions of the rename and reorder buffer block.
package rrrob_pkg;

   localparam int REG_COUNT = 32;
   localparam int ROB_DEPTH = 16;
   localparam int REG_AW    = $clog2(REG_COUNT);
   localparam int ROB_AW    = $clog2(ROB_DEPTH);
   localparam int OCC_W     = $clog2(ROB_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_DISPATCH  = 2'd0,
      MODE_WRITEBACK = 2'd1,
      MODE_COMMIT    = 2'd2,
      MODE_REPORT    = 2'd3
   } mode_type;

   localparam logic [2:0] KIND_ALU    = 3'd0;
   localparam logic [2:0] KIND_LOAD   = 3'd1;
   localparam logic [2:0] KIND_STORE  = 3'd2;
   localparam logic [2:0] KIND_BRANCH = 3'd3;
   localparam logic [2:0] KIND_JUMP   = 3'd4;

   localparam logic [3:0] STAT_STALL      = 4'd0;
   localparam logic [3:0] STAT_DISPATCHED = 4'd1;
   localparam logic [3:0] STAT_RETIRED    = 4'd2;
   localparam logic [3:0] STAT_STORE      = 4'd3;
   localparam logic [3:0] STAT_BRANCH_OK  = 4'd4;
   localparam logic [3:0] STAT_MISPREDICT = 4'd5;
   localparam logic [3:0] STAT_EXCEPTION  = 4'd6;
   localparam logic [3:0] STAT_HALTED     = 4'd7;
   localparam logic [3:0] STAT_WRITTEN    = 4'd8;

   localparam logic [31:0] NO_DEST = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_WB, S_CM, S_CM2
   } state_type;

   // Input beat payload, last member in the lowest bits.
   typedef struct packed {
      logic [31:0] st_word_addr;
      logic        fault;
      logic [31:0] value;
      logic [3:0]  tag;
      logic [15:0] pred_next_pc;
      logic [15:0] inst_pc;
      logic        uses_src2;
      logic [4:0]  src2_reg;
      logic [4:0]  src1_reg;
      logic [4:0]  dest_reg;
      logic [2:0]  kind;
   } req_item_type;

   typedef struct packed {
      logic        pad;
      logic        taken;
      logic [31:0] data_out;
      logic [31:0] addr_out;
      logic [3:0]  op2_tag;
      logic [31:0] op2_value;
      logic        op2_ready;
      logic [3:0]  op1_tag;
      logic [31:0] op1_value;
      logic        op1_ready;
      logic [3:0]  entry_tag;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] dest;
      logic [15:0] pc;
      logic [15:0] pred;
      logic [2:0]  kind;
      logic        rdy;
      logic        exc;
   } rob_entry_type;

   function automatic logic [ROB_AW-1:0] next_ptr(input logic [ROB_AW-1:0] p);
      logic [ROB_AW-1:0] r;
      if (32'(p) == ROB_DEPTH - 1) begin
         r = '0;
      end else begin
         r = p + ROB_AW'(1);
      end
      return r;
   endfunction

   function automatic logic reg_ok(input logic [4:0] r);
      return (r != 5'd0) && (32'(r) < REG_COUNT);
   endfunction

   function automatic logic tag_ok(input logic [3:0] t);
      return 32'(t) < ROB_DEPTH;
   endfunction

endpackage

[src/register_rename_reorder_buffer_top.sv]
// Rename table, reorder buffer and architectural register file of an out-of-order core.
// One beat is handled at a time and the next is accepted once the result has been taken:
// a halted answer is given on acceptance, a full-buffer stall or an empty-buffer commit
// from the first read state; a commit that writes a register finishes its alias check while
// the result waits. Reads go through the read ports of the three memories (register file,
// alias table, buffer entries), each read one address per cycle with registered data, so a
// dispatch resolves each source through an alias and register read together, then an entry
// read, and a writeback or store report reads the entry before it writes it.
// Alias valid bits live in flip-flops, so a flush takes effect at once; a written bit per
// architectural register makes a never-written register read as zero; buffer entries
// are defined only once allocated or written.
module register_rename_reorder_buffer_top
   import rrrob_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kind, dest_reg, src1_reg, src2_reg, uses_src2, inst_pc, pred_next_pc, tag, value,
   // fault, st_word_addr
   input  logic [119:0] req_tdata,
   // mode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // entry_tag, op1_ready, op1_value, op1_tag, op2_ready, op2_value, op2_tag, addr_out,
   // data_out, taken, zero pad
   output logic [143:0] rsp_tdata,
   // status
   output logic [3:0]   rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [16:0]  csr_wr_data
);

   state_type         state_ff, state_in;
   req_item_type      item_ff, item_in;
   mode_type          mode_ff, mode_in;
   logic              halted_ff, halted_in;
   logic [ROB_AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic [REG_COUNT-1:0] arch_set_ff, arch_set_in;
   logic [16:0]       mem_words_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_status_ff, rsp_status_in;
   rsp_item_type      rsp_ff, rsp_in;
   logic              sv_valid_ff, sv_valid_in, sv_use_ff, sv_use_in;
   logic [ROB_AW-1:0] sv_tag_ff, sv_tag_in;
   logic [31:0]       sv_val_ff, sv_val_in;
   logic [REG_AW-1:0] sv_reg_ff, sv_reg_in;

   logic              arch_we, alias_we, entry_we;
   logic [REG_AW-1:0] arch_wa, arch_ra, alias_wa, alias_ra;
   logic [31:0]       arch_wd, arch_rd;
   logic [ROB_AW-1:0] alias_wd, alias_rd, entry_wa, entry_ra;
   rob_entry_type     entry_wd, entry_rd;

   logic              req_accept;
   logic              use1, use2, dest_ok, st_bad;

   rrrob_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_arch (
      .clock(clock), .wr_en(arch_we), .wr_addr(arch_wa), .wr_data(arch_wd),
      .rd_addr(arch_ra), .rd_data(arch_rd)
   );

   rrrob_ram #(.WIDTH(ROB_AW), .DEPTH(REG_COUNT)) u_alias (
      .clock(clock), .wr_en(alias_we), .wr_addr(alias_wa), .wr_data(alias_wd),
      .rd_addr(alias_ra), .rd_data(alias_rd)
   );

   rrrob_ram #(.WIDTH($bits(rob_entry_type)), .DEPTH(ROB_DEPTH)) u_entry (
      .clock(clock), .wr_en(entry_we), .wr_addr(entry_wa), .wr_data(entry_wd),
      .rd_addr(entry_ra), .rd_data(entry_rd)
   );

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign use1    = (item_ff.kind != KIND_JUMP) && reg_ok(item_ff.src1_reg);
   assign use2    = (item_ff.kind != KIND_JUMP) && item_ff.uses_src2
                    && reg_ok(item_ff.src2_reg);
   assign dest_ok = ((item_ff.kind == KIND_ALU) || (item_ff.kind == KIND_LOAD))
                    && reg_ok(item_ff.dest_reg);
   assign st_bad  = entry_rd.dest[31] || (entry_rd.dest >= {15'd0, mem_words_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         halted_ff    <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         valid_ff     <= '0;
         arch_set_ff  <= '0;
         mem_words_ff <= 17'd1024;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         valid_ff     <= valid_in;
         arch_set_ff  <= arch_set_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mem_words_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      mode_ff       <= mode_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ff        <= rsp_in;
      sv_valid_ff   <= sv_valid_in;
      sv_use_ff     <= sv_use_in;
      sv_tag_ff     <= sv_tag_in;
      sv_val_ff     <= sv_val_in;
      sv_reg_ff     <= sv_reg_in;
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      mode_in       = mode_ff;
      halted_in     = halted_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      valid_in      = valid_ff;
      arch_set_in   = arch_set_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_in        = rsp_ff;
      sv_valid_in   = sv_valid_ff;
      sv_use_in     = sv_use_ff;
      sv_tag_in     = sv_tag_ff;
      sv_val_in     = sv_val_ff;
      sv_reg_in     = sv_reg_ff;
      arch_we       = 1'b0;
      arch_wa       = REG_AW'(item_ff.dest_reg);
      arch_wd       = entry_rd.value;
      arch_ra       = REG_AW'(item_ff.src1_reg);
      alias_we      = 1'b0;
      alias_wa      = REG_AW'(item_ff.dest_reg);
      alias_wd      = tail_ff;
      alias_ra      = REG_AW'(item_ff.src1_reg);
      entry_we      = 1'b0;
      entry_wa      = tail_ff;
      entry_wd      = entry_rd;
      entry_ra      = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               item_in = req_tdata;
               if (item_in.kind > KIND_JUMP) begin
                  item_in.kind = KIND_ALU;
               end
               mode_in = mode_type'(req_tuser);
               if (halted_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_HALTED;
                  rsp_in        = '0;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_RD0: begin
            rsp_in        = '0;
            rsp_status_in = STAT_STALL;
            unique case (mode_ff)
               MODE_DISPATCH: begin
                  if (32'(occ_ff) >= ROB_DEPTH) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_RD1;
                  end
               end
               MODE_WRITEBACK, MODE_REPORT: begin
                  entry_ra = ROB_AW'(item_ff.tag);
                  if (!tag_ok(item_ff.tag)) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_WB;
                  end
               end
               default: begin
                  if (occ_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_CM;
                  end
               end
            endcase
         end
         S_RD1: begin
            // Alias and register data of the first source are here; start the second.
            sv_use_in   = use1;
            sv_valid_in = valid_ff[REG_AW'(item_ff.src1_reg)];
            sv_tag_in   = alias_rd;
            sv_val_in   = arch_set_ff[REG_AW'(item_ff.src1_reg)] ? arch_rd : '0;
            entry_ra    = alias_rd;
            alias_ra    = REG_AW'(item_ff.src2_reg);
            arch_ra     = REG_AW'(item_ff.src2_reg);
            state_in    = S_RD2;
         end
         S_RD2: begin
            rsp_in           = '0;
            rsp_in.op1_ready = 1'b1;
            if (sv_use_ff) begin
               if (!sv_valid_ff) begin
                  rsp_in.op1_value = sv_val_ff;
               end else if (entry_rd.rdy) begin
                  rsp_in.op1_value = entry_rd.value;
               end else begin
                  rsp_in.op1_ready = 1'b0;
                  rsp_in.op1_tag   = 4'(sv_tag_ff);
               end
            end
            sv_use_in   = use2;
            sv_valid_in = valid_ff[REG_AW'(item_ff.src2_reg)];
            sv_tag_in   = alias_rd;
            sv_val_in   = arch_set_ff[REG_AW'(item_ff.src2_reg)] ? arch_rd : '0;
            entry_ra    = alias_rd;
            state_in    = S_RD3;
         end
         S_RD3: begin
            rsp_in.op2_ready = 1'b1;
            if (sv_use_ff) begin
               if (!sv_valid_ff) begin
                  rsp_in.op2_value = sv_val_ff;
               end else if (entry_rd.rdy) begin
                  rsp_in.op2_value = entry_rd.value;
               end else begin
                  rsp_in.op2_ready = 1'b0;
                  rsp_in.op2_tag   = 4'(sv_tag_ff);
               end
            end
            rsp_in.entry_tag = 4'(tail_ff);
            rsp_status_in    = STAT_DISPATCHED;
            rsp_valid_in     = 1'b1;
            entry_we         = 1'b1;
            entry_wd.value   = '0;
            entry_wd.dest    = dest_ok ? 32'(item_ff.dest_reg) : NO_DEST;
            entry_wd.pc      = item_ff.inst_pc;
            entry_wd.pred    = item_ff.pred_next_pc;
            entry_wd.kind    = item_ff.kind;
            entry_wd.rdy     = (item_ff.kind == KIND_JUMP);
            entry_wd.exc     = 1'b0;
            if (dest_ok) begin
               alias_we = 1'b1;
               valid_in[REG_AW'(item_ff.dest_reg)] = 1'b1;
            end
            tail_in  = next_ptr(tail_ff);
            occ_in   = occ_ff + OCC_W'(1);
            state_in = S_IDLE;
         end
         S_WB: begin
            entry_we       = 1'b1;
            entry_wa       = ROB_AW'(item_ff.tag);
            entry_wd.value = item_ff.value;
            entry_wd.rdy   = 1'b1;
            if (mode_ff == MODE_WRITEBACK) begin
               entry_wd.exc = entry_rd.exc | item_ff.fault;
            end else begin
               entry_wd.dest = item_ff.st_word_addr;
            end
            rsp_status_in    = STAT_WRITTEN;
            rsp_in.entry_tag = item_ff.tag;
            rsp_valid_in     = 1'b1;
            state_in         = S_IDLE;
         end
         S_CM: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (entry_rd.rdy) begin
               rsp_in.entry_tag = 4'(head_ff);
               if (entry_rd.exc || ((entry_rd.kind == KIND_STORE) && st_bad)) begin
                  // Redirect to the faulting instruction and stop for good.
                  rsp_status_in   = STAT_EXCEPTION;
                  rsp_in.addr_out = 32'(entry_rd.pc);
                  halted_in       = 1'b1;
                  tail_in         = head_ff;
                  occ_in          = '0;
                  valid_in        = '0;
               end else begin
                  head_in = next_ptr(head_ff);
                  occ_in  = occ_ff - OCC_W'(1);
                  if (entry_rd.kind == KIND_STORE) begin
                     rsp_status_in   = STAT_STORE;
                     rsp_in.addr_out = entry_rd.dest;
                     rsp_in.data_out = entry_rd.value;
                  end else if (entry_rd.kind == KIND_BRANCH) begin
                     rsp_in.taken = entry_rd.value != (32'(entry_rd.pc) + 32'd1);
                     if (32'(entry_rd.pred) != entry_rd.value) begin
                        rsp_status_in   = STAT_MISPREDICT;
                        rsp_in.addr_out = entry_rd.value;
                        tail_in         = next_ptr(head_ff);
                        occ_in          = '0;
                        valid_in        = '0;
                     end else begin
                        rsp_status_in = STAT_BRANCH_OK;
                     end
                  end else begin
                     rsp_status_in = STAT_RETIRED;
                     if (((entry_rd.kind == KIND_ALU) || (entry_rd.kind == KIND_LOAD))
                         && (entry_rd.dest < 32'(REG_COUNT))) begin
                        arch_we   = 1'b1;
                        arch_wa   = REG_AW'(entry_rd.dest);
                        arch_set_in[REG_AW'(entry_rd.dest)] = 1'b1;
                        alias_ra  = REG_AW'(entry_rd.dest);
                        sv_reg_in = REG_AW'(entry_rd.dest);
                        sv_tag_in = head_ff;
                        state_in  = S_CM2;
                     end
                  end
               end
            end
         end
         S_CM2: begin
            // Drop the alias only if it still names the entry that just retired.
            if (valid_ff[sv_reg_ff] && (alias_rd == sv_tag_ff)) begin
               valid_in[sv_reg_ff] = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= ROB_DEPTH)
      else $error("buffer occupancy beyond its depth");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt cleared without reset");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && (occ_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty buffer with head and tail apart");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((state_ff == S_IDLE) || (state_ff == S_CM2)))
      else $error("result pending while an item is still in work");

endmodule

[src/rrrob_ram.sv]
// Generic single-write, single-read memory with a registered read port.
module rrrob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
